// File: sv/csa_pkg.sv
// Package with a constant shared by the complex squash activation block.
package csa_pkg;
  localparam int unsigned GuardBits = 16;
endpackage

// File: sv/complex_squash_activation.sv
// Top level of the complex squash activation pipeline.
// The block takes one complex item per cycle on the slave side and returns
// z / (|z| + 1) for it on the master side. The input parts are signed
// fixed point with DATA_WIDTH-4 fraction bits. The output parts are signed
// fixed point with DATA_WIDTH-1 fraction bits, rounded to nearest with ties
// away from zero and clamped to +/-(2^(DATA_WIDTH-1)-1). The work runs
// through a fixed pipeline: one stage takes magnitudes, one stage squares,
// one stage sums, one stage loads the root, then one square-root digit per
// stage, one stage forms the divisor, one quotient bit per stage for each
// part, and a final stage rounds, clamps and restores the signs. An item
// therefore passes through 2*DATA_WIDTH+GuardBits+6 register stages (54 at
// the default width). A new item is accepted in every cycle in which the
// pipeline is not held. When the master side stalls, the whole pipeline
// holds, so tready follows the downstream tready whenever the output
// register is full. The tlast flag travels alongside each item and does not
// affect the arithmetic.
module complex_squash_activation #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // Bits from low: real_part, imag_part.
  input  logic [2*DATA_WIDTH-1:0]   s_axis_tdata_i,
  input  logic                      s_axis_tlast_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // Bits from low: real_out, imag_out.
  output logic [2*DATA_WIDTH-1:0]   m_axis_tdata_o,
  output logic                      m_axis_tlast_o
);
  localparam int unsigned G    = csa_pkg::GuardBits;
  localparam int unsigned SW   = 2 * DATA_WIDTH + 1;
  // Root digits: ceil(SW/2) data digit pairs plus G guard digits.
  localparam int unsigned NP   = (SW + 1) / 2;
  localparam int unsigned RS   = NP + G;
  localparam int unsigned RW   = RS + 2;
  localparam int unsigned DW   = RS + 1;
  localparam int unsigned QN   = DATA_WIDTH - 1;
  localparam int unsigned NRW  = DW + 1;
  localparam int unsigned NST  = 3 + 1 + RS + 1 + QN + 1;

  // Pipeline advances when the last stage is empty or taken.
  logic adv;
  logic [NST-1:0] v_q;
  assign adv = !v_q[NST-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Stage 0: magnitudes and signs.
  logic [DATA_WIDTH:0] mre0_q, mim0_q;
  logic nre0_q, nim0_q, l0_q;
  // Stage 1: squares.
  logic [2*DATA_WIDTH:0] sre1_q, sim1_q;
  logic [DATA_WIDTH:0] mre1_q, mim1_q;
  logic nre1_q, nim1_q, l1_q;
  // Stage 2: sum.
  logic [SW-1:0] sum2_q;
  logic [DATA_WIDTH:0] mre2_q, mim2_q;
  logic nre2_q, nim2_q, l2_q;

  logic [DATA_WIDTH-1:0] re_in, im_in;
  assign re_in = s_axis_tdata_i[DATA_WIDTH-1:0];
  assign im_in = s_axis_tdata_i[2*DATA_WIDTH-1:DATA_WIDTH];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mre0_q <= re_in[DATA_WIDTH-1] ? ({1'b0, ~re_in} + 1'b1) : {1'b0, re_in};
      mim0_q <= im_in[DATA_WIDTH-1] ? ({1'b0, ~im_in} + 1'b1) : {1'b0, im_in};
      nre0_q <= re_in[DATA_WIDTH-1];
      nim0_q <= im_in[DATA_WIDTH-1];
      l0_q   <= s_axis_tlast_i;
      sre1_q <= (2*DATA_WIDTH+1)'(mre0_q * mre0_q);
      sim1_q <= (2*DATA_WIDTH+1)'(mim0_q * mim0_q);
      mre1_q <= mre0_q; mim1_q <= mim0_q;
      nre1_q <= nre0_q; nim1_q <= nim0_q; l1_q <= l0_q;
      sum2_q <= SW'(sre1_q) + SW'(sim1_q);
      mre2_q <= mre1_q; mim2_q <= mim1_q;
      nre2_q <= nre1_q; nim2_q <= nim1_q; l2_q <= l1_q;
    end
  end

  // Square-root stages: one digit per stage.
  logic [2*NP-1:0]     rs_s_q  [RS+1];
  logic [RW-1:0]       rs_r_q  [RS+1];
  logic [RS-1:0]       rs_t_q  [RS+1];
  logic [DATA_WIDTH:0] rs_a_q  [RS+1];
  logic [DATA_WIDTH:0] rs_b_q  [RS+1];
  logic [2:0]          rs_f_q  [RS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rs_s_q[0] <= (2*NP)'(sum2_q);
      rs_r_q[0] <= '0;
      rs_t_q[0] <= '0;
      rs_a_q[0] <= mre2_q;
      rs_b_q[0] <= mim2_q;
      rs_f_q[0] <= {l2_q, nim2_q, nre2_q};
    end
  end

  for (genvar i = 0; i < RS; i++) begin : g_sqrt
    logic [RW-1:0] rem, trial;
    logic [1:0] pair;
    always_comb begin
      pair  = (i < NP) ? rs_s_q[i][2*NP-1:2*NP-2] : 2'b00;
      rem   = {rs_r_q[i][RW-3:0], pair};
      trial = {rs_t_q[i], 2'b01};
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rs_s_q[i+1] <= rs_s_q[i] << 2;
        rs_r_q[i+1] <= (rem >= trial) ? rem - trial : rem;
        rs_t_q[i+1] <= {rs_t_q[i][RS-2:0], rem >= trial};
        rs_a_q[i+1] <= rs_a_q[i];
        rs_b_q[i+1] <= rs_b_q[i];
        rs_f_q[i+1] <= rs_f_q[i];
      end
    end
  end

  // Divider setup and quotient stages, one bit per stage for each part.
  localparam logic [DW-1:0] One = DW'(1) << (DATA_WIDTH - 4 + G);
  logic [DW-1:0]  dv_q [QN+1];
  logic [NRW-1:0] ra_q [QN+1], rb_q [QN+1];
  logic [QN-1:0]  qa_q [QN+1], qb_q [QN+1];
  logic [2:0]     df_q [QN+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= DW'(rs_t_q[RS]) + One;
      ra_q[0] <= NRW'(rs_a_q[RS]) << G;
      rb_q[0] <= NRW'(rs_b_q[RS]) << G;
      qa_q[0] <= '0;
      qb_q[0] <= '0;
      df_q[0] <= rs_f_q[RS];
    end
  end

  for (genvar k = 0; k < QN; k++) begin : g_div
    logic [NRW-1:0] sa, sb, dn;
    logic ga, gb;
    always_comb begin
      sa = ra_q[k] << 1;
      sb = rb_q[k] << 1;
      dn = NRW'(dv_q[k]);
      ga = sa >= dn;
      gb = sb >= dn;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        ra_q[k+1] <= ga ? sa - dn : sa;
        rb_q[k+1] <= gb ? sb - dn : sb;
        qa_q[k+1] <= {qa_q[k][QN-2:0], ga};
        qb_q[k+1] <= {qb_q[k][QN-2:0], gb};
        dv_q[k+1] <= dv_q[k];
        df_q[k+1] <= df_q[k];
      end
    end
  end

  // Last bit decides rounding; ties round away from zero on the magnitude.
  logic [DW-1:0] fin_dn;
  logic [NRW-1:0] fa_sh, fb_sh;
  logic rnd_a, rnd_b;
  logic [QN:0] ra_sum, rb_sum;
  logic [DATA_WIDTH-1:0] oa, ob, sa_o, sb_o;
  localparam logic [QN:0] MaxMag = (QN+1)'((1 << (DATA_WIDTH-1)) - 1);

  always_comb begin
    fin_dn = dv_q[QN];
    fa_sh  = ra_q[QN] << 1;
    fb_sh  = rb_q[QN] << 1;
    rnd_a  = fa_sh >= NRW'(fin_dn);
    rnd_b  = fb_sh >= NRW'(fin_dn);
    ra_sum = {1'b0, qa_q[QN]} + (QN+1)'(rnd_a);
    rb_sum = {1'b0, qb_q[QN]} + (QN+1)'(rnd_b);
    oa = (ra_sum > MaxMag) ? DATA_WIDTH'(MaxMag) : DATA_WIDTH'(ra_sum);
    ob = (rb_sum > MaxMag) ? DATA_WIDTH'(MaxMag) : DATA_WIDTH'(rb_sum);
    sa_o = df_q[QN][0] ? (~oa + 1'b1) : oa;
    sb_o = df_q[QN][1] ? (~ob + 1'b1) : ob;
  end

  logic [2*DATA_WIDTH-1:0] out_d_q;
  logic out_l_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_d_q <= {sb_o, sa_o};
      out_l_q <= df_q[QN][2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NST-2:0], s_axis_tvalid_i};
    end
  end

  assign m_axis_tvalid_o = v_q[NST-1];
  assign m_axis_tdata_o  = out_d_q;
  assign m_axis_tlast_o  = out_l_q;
endmodule

// File: tb/sv/tb.sv
// Testbench for the complex squash activation block.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned Width = 16;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned NumRandom = 1130;
  localparam int unsigned LongHold = 400;

  typedef struct packed {
    logic signed [Width-1:0] re;
    logic signed [Width-1:0] im;
    logic                    last;
  } cplx_t;

  typedef struct {
    cplx_t stim;
    bit    typed;
    cplx_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [2*Width-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [2*Width-1:0] m_tdata;
  logic m_tlast;

  cplx_t expected_q[$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned idle_cycles = 0;
  bit free_run = 1'b0;

  complex_squash_activation #(.DATA_WIDTH(Width)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // One part of z / (|z| + 1): the magnitude scaled to Q1.15, rounded and clamped.
  function automatic logic signed [Width-1:0] squash_part(logic signed [Width-1:0] part,
                                                          logic [127:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    mag = part[Width-1] ? 128'(-$signed(129'(part))) : 128'(part);
    mag = part[Width-1] ? 128'(1 << Width) - 128'(part[Width-1:0]) : mag;
    q = ((mag << (csa_pkg::GuardBits + Width)) / den + 1) >> 1;
    if (q > 128'((1 << (Width - 1)) - 1)) q = 128'((1 << (Width - 1)) - 1);
    return part[Width-1] ? -$signed(q[Width-1:0]) : $signed(q[Width-1:0]);
  endfunction

  function automatic cplx_t squash(cplx_t z);
    logic [127:0] mre;
    logic [127:0] mim;
    logic [127:0] scaled;
    logic [127:0] root;
    logic [127:0] cand;
    cplx_t r;
    mre = z.re[Width-1] ? 128'(1 << Width) - 128'(z.re[Width-1:0]) : 128'(z.re[Width-1:0]);
    mim = z.im[Width-1] ? 128'(1 << Width) - 128'(z.im[Width-1:0]) : 128'(z.im[Width-1:0]);
    scaled = (mre * mre + mim * mim) << (2 * csa_pkg::GuardBits);
    root = '0;
    for (int i = 40; i >= 0; i--) begin
      cand = root | (128'(1) << i);
      if (cand * cand <= scaled) root = cand;
    end
    root = root + (128'(1) << (Width - 4 + csa_pkg::GuardBits));
    r.re = squash_part(z.re, root);
    r.im = squash_part(z.im, root);
    r.last = z.last;
    return r;
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Offers one item and leaves tvalid high; the caller lowers it for gaps, the drain and the end.
  task automatic send(cplx_t z, bit typed, cplx_t want);
    s_tvalid <= 1'b1;
    s_tdata <= {z.im, z.re};
    s_tlast <= z.last;
    do @(posedge clk_i); while (!s_tready);
    expected_q.push_back(typed ? want : squash(z));
    n_sent++;
  endtask

  task automatic gap();
    int unsigned sel;
    int unsigned len;
    sel = $urandom_range(0, 19);
    len = free_run ? 0 : (sel < 13 ? 0 : (sel < 18 ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 40)));
    if (len > 0) begin
      s_tvalid <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [Width-1:0] rand_part();
    case ($urandom_range(0, 5))
      0: return $signed(Width'($urandom_range(0, 255)) - Width'(128));
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return '0;
      default: return $signed(Width'($urandom));
    endcase
  endfunction

  // Receiver: random stalls, one long hold-off, and a stretch of steady readiness.
  initial begin
    bit held;
    int unsigned sel;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && n_sent >= 300) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      sel = $urandom_range(0, 19);
      if (free_run || sel < 13) begin
        m_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        m_tready <= 1'b0;
        repeat (sel < 18 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk_i);
      end
    end
  end

  // Result checker: each accepted result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    cplx_t want;
    if (m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", m_tdata, 0);
      end else begin
        want = expected_q.pop_front();
        if (m_tdata[Width-1:0] !== want.re) report("real_out", m_tdata[Width-1:0], want.re);
        if (m_tdata[2*Width-1:Width] !== want.im)
          report("imag_out", m_tdata[2*Width-1:Width], want.im);
        if (m_tlast !== want.last) report("last_out", m_tlast, want.last);
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    row_t table_rows[$];
    cplx_t z;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: zero, extremes, the most negative value, and tensor ends.
    table_rows = '{
      '{'{16'sh0000, 16'sh0000, 1'b0}, 1'b1, '{16'sh0000, 16'sh0000, 1'b0}},
      '{'{16'sh0000, 16'sh0000, 1'b1}, 1'b1, '{16'sh0000, 16'sh0000, 1'b1}},
      '{'{16'sh8000, 16'sh0000, 1'b0}, 1'b1, '{-16'sd29127, 16'sh0000, 1'b0}},
      '{'{16'sh0000, 16'sh8000, 1'b1}, 1'b1, '{16'sh0000, -16'sd29127, 1'b1}},
      '{'{16'sh7fff, 16'sh0000, 1'b0}, 1'b0, '0},
      '{'{16'sh0000, 16'sh7fff, 1'b0}, 1'b0, '0},
      '{'{16'sh8000, 16'sh8000, 1'b0}, 1'b0, '0},
      '{'{16'sh7fff, 16'sh7fff, 1'b1}, 1'b0, '0},
      '{'{16'sh8000, 16'sh7fff, 1'b0}, 1'b0, '0},
      '{'{16'sh7fff, 16'sh8000, 1'b0}, 1'b0, '0},
      '{'{16'sh0001, 16'sh0000, 1'b0}, 1'b0, '0},
      '{'{16'shffff, 16'shffff, 1'b0}, 1'b0, '0},
      '{'{16'sh1000, 16'sh0000, 1'b0}, 1'b0, '0},
      '{'{16'sh0000, 16'shf000, 1'b0}, 1'b0, '0},
      '{'{16'sh0c00, 16'sh1000, 1'b1}, 1'b0, '0},
      '{'{16'sh5555, 16'shaaaa, 1'b0}, 1'b0, '0},
      '{'{16'shaaaa, 16'sh5555, 1'b1}, 1'b0, '0}
    };
    foreach (table_rows[i]) begin
      send(table_rows[i].stim, table_rows[i].typed, table_rows[i].want);
      gap();
    end

    for (int unsigned n = 0; n < NumRandom; n++) begin
      if (n == 600) begin
        // Let the pipeline drain completely before going on.
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk_i);
      end
      free_run = (n >= 800 && n < 900);
      z.re = rand_part();
      z.im = rand_part();
      z.last = ($urandom_range(0, 7) == 0);
      send(z, 1'b0, '0);
      gap();
    end
    s_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
